// ----- design/hufdec_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Shared codes, payload types and default sizes for the tree decoder.
// ----------------------------------------------------------------------------
package hufdec_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned CodeW = 16;
  localparam int unsigned LenW  = 5;

  localparam int unsigned NodeCountDef  = 512;
  localparam int unsigned MaxCodeLenDef = 16;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdDecode = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StMissing = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StateInit,
    StateIdle,
    StateRead,
    StateEval,
    StateNew,
    StateDone
  } state_e;

  typedef struct packed {
    logic             command;
    logic [SymW-1:0]  symbol;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
    logic             bit_req;
  } in_item_t;

  typedef struct packed {
    logic            symbol_valid;
    logic [SymW-1:0] decoded_symbol;
    logic [1:0]      status;
  } out_item_t;

endpackage

// ----- design/hufdec_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel that carries one payload item per transfer.
// ----------------------------------------------------------------------------
interface hufdec_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/hufdec_node_mem.sv -----
// ----------------------------------------------------------------------------
// Node table memory
// One write port and one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module hufdec_node_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Width = 27
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // Hold the last read word while no read is issued.
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/huffman_tree_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// Huffman tree bit decoder
// Builds a binary code tree in a node table and walks it one bit per item.
// ----------------------------------------------------------------------------
// Decode: one bit per cycle sustained while the output is free and no insert
//   runs; the result passes one node table read, then the output register.
// Insert: each code bit reads, then evaluates a node; a missing child is first
//   linked and cleared. The leaf is then marked and the result posted.
// Reset: asynchronous, active low; the Init state after reset clears the root
//   entry before the first transfer is taken.
module huffman_tree_bit_decoder import hufdec_pkg::*; #(
  parameter int unsigned NODE_COUNT   = NodeCountDef,
  parameter int unsigned MAX_CODE_LEN = MaxCodeLenDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hufdec_stream_if.sink   in_i,
  hufdec_stream_if.source out_o
);

  localparam int unsigned NodeW = $clog2(NODE_COUNT);
  localparam int unsigned UsedW = $clog2(NODE_COUNT + 1);
  localparam int unsigned CntW  = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned WordW = 1 + SymW + 2 * NodeW;

  // One node table word: leaf mark, leaf symbol and both child pointers.
  // A child pointer of zero means no child, since the root is never a child.
  typedef struct packed {
    logic             leaf;
    logic [SymW-1:0]  sym;
    logic [NodeW-1:0] left;
    logic [NodeW-1:0] right;
  } node_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [NodeW-1:0] node_q, node_d;       // insert walk position
  logic [CntW-1:0]  cnt_q, cnt_d;         // code bits still to walk
  logic [CodeW-1:0] code_q, code_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic [UsedW-1:0] used_q, used_d;       // allocated nodes, root included
  status_e          ins_st_q, ins_st_d;

  logic [NodeW-1:0] walk_q;               // decode position
  node_t            cur_q;                // copy of the word at walk_q
  node_t            root_q;               // copy of the root word

  logic             s2_q;                 // decode read in flight
  logic             s2_miss_q;            // selected child did not exist
  logic [NodeW-1:0] s2_node_q;

  logic             out_valid_q;
  out_item_t        out_q;

  // --------------------------------------------------------------------------
  // Node table
  // --------------------------------------------------------------------------
  logic             mem_we;
  logic [NodeW-1:0] mem_waddr;
  node_t            mem_wdata;
  logic             mem_re;
  logic [NodeW-1:0] mem_raddr;
  logic [WordW-1:0] mem_rdata;
  node_t            rd_word;

  hufdec_node_mem #(
    .Depth (NODE_COUNT),
    .Width (WordW)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (WordW'(mem_wdata)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_word = node_t'(mem_rdata);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  in_item_t in_item;
  logic     out_free, s2_adv, in_ready, in_fire, dec_fire, ins_fire;

  assign in_item  = in_i.data;
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_adv   = s2_q && out_free;
  // A decode result leaves the read stage in the same cycle a new item enters.
  assign in_ready = (state_q == StateIdle) && (!s2_q || s2_adv);
  assign in_fire  = in_i.valid && in_ready;
  assign dec_fire = in_fire && (in_item.command == CmdDecode);
  assign ins_fire = in_fire && (in_item.command == CmdInsert);

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // --------------------------------------------------------------------------
  // Decode path: forward the word that just came back so the next bit can
  // select its child in the same cycle.
  // --------------------------------------------------------------------------
  logic [NodeW-1:0] walk_eff;
  node_t            cur_eff;
  logic [NodeW-1:0] dec_child;

  always_comb begin
    walk_eff = walk_q;
    cur_eff  = cur_q;
    if (s2_q) begin
      if (s2_miss_q || rd_word.leaf) begin
        // Missing branch or leaf reached: go back to the root.
        walk_eff = '0;
        cur_eff  = root_q;
      end else begin
        walk_eff = s2_node_q;
        cur_eff  = rd_word;
      end
    end
  end

  assign dec_child = in_item.bit_req ? cur_eff.right : cur_eff.left;

  // --------------------------------------------------------------------------
  // Insert path
  // --------------------------------------------------------------------------
  logic [CntW-1:0]  pos;
  logic [CodeW-1:0] code_shift;
  logic             code_bit;
  logic [NodeW-1:0] ev_child;
  logic [CntW-1:0]  cnt_sat;
  logic             table_full;

  assign pos        = cnt_q - CntW'(1);
  // Positions beyond the code word shift out to zero.
  assign code_shift = code_q >> pos;
  assign code_bit   = code_shift[0];
  assign ev_child   = code_bit ? rd_word.right : rd_word.left;
  assign table_full = (used_q == UsedW'(NODE_COUNT));
  assign cnt_sat    = (32'(in_item.code_length) > MAX_CODE_LEN) ?
                      CntW'(MAX_CODE_LEN) : CntW'(in_item.code_length);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StateInit: state_d = StateIdle;
      StateIdle: begin
        if (ins_fire) begin
          state_d = (in_item.code_length == '0) ? StateDone : StateRead;
        end
      end
      StateRead: state_d = StateEval;
      StateEval: begin
        if (cnt_q == '0) begin
          state_d = StateDone;
        end else if (ev_child != '0) begin
          state_d = StateRead;
        end else if (table_full) begin
          state_d = StateDone;
        end else begin
          state_d = StateNew;
        end
      end
      StateNew:  state_d = StateRead;
      StateDone: begin
        if (out_free) begin
          state_d = StateIdle;
        end
      end
      default:   state_d = StateIdle;
    endcase
  end

  // Outputs and datapath of the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = rd_word;
    mem_re    = dec_fire && (dec_child != '0);
    mem_raddr = dec_child;
    node_d    = node_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    sym_d     = sym_q;
    used_d    = used_q;
    ins_st_d  = ins_st_q;
    case (state_q)
      StateInit: begin
        // Clear the root entry.
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '0;
      end
      StateIdle: begin
        if (ins_fire) begin
          node_d   = '0;
          cnt_d    = cnt_sat;
          code_d   = in_item.code_bits;
          sym_d    = in_item.symbol;
          ins_st_d = StOk;
        end
      end
      StateRead: begin
        mem_re    = 1'b1;
        mem_raddr = node_q;
      end
      StateEval: begin
        if (cnt_q == '0) begin
          // End of the code: mark the node as a leaf, keep its children.
          mem_we         = 1'b1;
          mem_wdata.leaf = 1'b1;
          mem_wdata.sym  = sym_q;
        end else if (ev_child != '0) begin
          node_d = ev_child;
          cnt_d  = cnt_q - CntW'(1);
        end else if (table_full) begin
          ins_st_d = StFull;
        end else begin
          // Link the next free node into the parent.
          mem_we = 1'b1;
          if (code_bit) begin
            mem_wdata.right = NodeW'(used_q);
          end else begin
            mem_wdata.left = NodeW'(used_q);
          end
        end
      end
      StateNew: begin
        // Clear the freshly allocated node and step into it.
        mem_we    = 1'b1;
        mem_waddr = NodeW'(used_q);
        mem_wdata = '0;
        node_d    = NodeW'(used_q);
        used_d    = used_q + UsedW'(1);
        cnt_d     = cnt_q - CntW'(1);
      end
      StateDone: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateInit;
      used_q      <= UsedW'(1);
      walk_q      <= '0;
      cur_q       <= '0;
      root_q      <= '0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;

      // Keep the cached words coherent with every table write.
      if (mem_we && (mem_waddr == '0)) begin
        root_q <= mem_wdata;
      end
      if (s2_adv) begin
        walk_q <= walk_eff;
        cur_q  <= cur_eff;
      end else if (mem_we && (mem_waddr == walk_q)) begin
        cur_q <= mem_wdata;
      end

      if (dec_fire) begin
        s2_q <= 1'b1;
      end else if (s2_adv) begin
        s2_q <= 1'b0;
      end

      if (s2_adv || ((state_q == StateDone) && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    cnt_q    <= cnt_d;
    code_q   <= code_d;
    sym_q    <= sym_d;
    ins_st_q <= ins_st_d;

    if (dec_fire) begin
      s2_miss_q <= (dec_child == '0);
      s2_node_q <= dec_child;
    end

    if (s2_adv) begin
      if (s2_miss_q) begin
        out_q.symbol_valid   <= 1'b0;
        out_q.decoded_symbol <= '0;
        out_q.status         <= StMissing;
      end else if (rd_word.leaf) begin
        out_q.symbol_valid   <= 1'b1;
        out_q.decoded_symbol <= rd_word.sym;
        out_q.status         <= StOk;
      end else begin
        out_q.symbol_valid   <= 1'b0;
        out_q.decoded_symbol <= '0;
        out_q.status         <= StOk;
      end
    end else if ((state_q == StateDone) && out_free) begin
      out_q.symbol_valid   <= 1'b0;
      out_q.decoded_symbol <= '0;
      out_q.status         <= ins_st_q;
    end
  end

endmodule

// ----- design/hufdec_checker.sv -----
// ----------------------------------------------------------------------------
// Huffman tree decoder checker
// Port-level properties of the decoder, attached by bind.
// ----------------------------------------------------------------------------
module hufdec_props import hufdec_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic            symbol_valid_i,
  input logic [SymW-1:0] decoded_symbol_i,
  input logic [1:0]      status_i
);

  // The cycle after reset clears the root, so no transfer is taken then.
  a_no_ready_after_reset : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input ready in the first cycle after reset");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_symbol_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && symbol_valid_i |-> status_i == StOk)
    else $error("symbol emitted with error status");

  a_no_symbol_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !symbol_valid_i |-> decoded_symbol_i == '0)
    else $error("nonzero symbol without symbol_valid");

endmodule

bind huffman_tree_bit_decoder hufdec_props u_hufdec_props (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .symbol_valid_i   (out_o.data.symbol_valid),
  .decoded_symbol_i (out_o.data.decoded_symbol),
  .status_i         (out_o.data.status)
);
